// File: hdl/itrf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrf_pkg: shared types and constants for the radix text formatter
// Payload structs, controller state, command/status bundles and the
// digit-to-ASCII mapping.
// ----------------------------------------------------------------------------
package itrf_pkg;

  localparam int unsigned MAX_CHARS     = 64;
  localparam int unsigned VALUE_BITS    = 64;
  // quotient bits resolved per divider cycle
  localparam int unsigned BITS_PER_STEP = 8;
  localparam int unsigned DIV_STEPS     = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int unsigned QUOT_W        = DIV_STEPS * BITS_PER_STEP;
  localparam int unsigned DIGIT_AW      = $clog2(VALUE_BITS);
  localparam int unsigned STEP_W        = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam int unsigned CNT_W         = 7;

  localparam logic [4:0] RADIX_MIN = 5'd2;
  localparam logic [4:0] RADIX_MAX = 5'd16;

  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
  localparam logic [7:0] CH_X     = 8'h78;  // 'x'
  localparam logic [7:0] CH_LOW_A = 8'h61;  // 'a'
  localparam logic [7:0] CH_UP_A  = 8'h41;  // 'A'

  typedef struct packed {
    logic signed [63:0] value;
    logic               is_signed;
    logic [4:0]         radix;
    logic               uppercase;
    logic [6:0]         width;
    logic [6:0]         precision;
    logic               left_justify;
    logic               zero_pad;
    logic               pointer_prefix;
  } itrf_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } itrf_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FORMAT,
    ST_FETCH,
    ST_EMIT
  } itrf_state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic format;
    logic emit;
  } itrf_cmd_t;

  typedef struct packed {
    logic step_last;  // divider finishes a digit this cycle
    logic div_more;   // another digit follows
    logic char_last;  // current character ends the text
    logic out_free;   // output register can take a character
  } itrf_sts_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CH_UP_A : CH_LOW_A;
    if (d < 4'd10) begin
      digit_char = CH_ZERO + 8'(d);
    end else begin
      digit_char = base + 8'(d - 4'd10);
    end
  endfunction

endpackage

// File: hdl/itrf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrf_ctrl: conversion sequencer
// Steps the datapath through digit generation, field layout and character
// emission for one transaction at a time.
// ----------------------------------------------------------------------------
module itrf_ctrl import itrf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  itrf_sts_t sts_i,
  output itrf_cmd_t cmd_o
);

  itrf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.step_last && !sts_i.div_more) begin
          state_d = ST_FORMAT;
        end
      end
      ST_FORMAT: begin
        cmd_o.format = 1'b1;
        state_d      = ST_FETCH;
      end
      // digit store read latency
      ST_FETCH: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = sts_i.char_last ? ST_IDLE : ST_FETCH;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/itrf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrf_dp: formatter datapath
// Radix divider (several quotient bits per cycle), digit store, field
// layout arithmetic, character selection and the output register.
// ----------------------------------------------------------------------------
module itrf_dp import itrf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  itrf_in_t  in_data_i,
  input  itrf_cmd_t cmd_i,
  input  logic      out_ready_i,
  output itrf_sts_t sts_o,
  output logic      out_valid_o,
  output itrf_out_t out_data_o
);

  // options
  logic [4:0]       radix_q;
  logic             upper_q, left_q, zpad_q, ptr_q;
  logic [6:0]       width_q, prec_q;

  // divider
  logic [QUOT_W-1:0] quot_q, quot_w;
  logic [3:0]        rem_q, rem_w;
  logic [4:0]        trial_w;
  logic              ge_w;
  logic [STEP_W-1:0] step_q;
  logic [CNT_W-1:0]  ndig_q;

  // digit store
  logic [3:0]          digit_mem [VALUE_BITS];
  logic [3:0]          rdata_q;
  logic [CNT_W-1:0]    raddr_full_w;
  logic [DIGIT_AW-1:0] raddr_w;

  // layout
  logic [7:0]       ext_w, a_w, tot_w;
  logic [CNT_W-1:0] b_zero_q, b_pad_q, b_pfx_q, total_q, len_q, k_q;

  // input magnitude
  logic [VALUE_BITS-1:0] val_w, mag_w;

  logic [7:0] char_w;
  itrf_out_t  out_q;
  logic       out_valid_q;
  logic [4:0] radix_in_w;

  assign val_w = in_data_i.value[VALUE_BITS-1:0];
  assign mag_w = (in_data_i.is_signed && val_w[VALUE_BITS-1]) ? (~val_w + 1'b1) : val_w;

  always_comb begin
    radix_in_w = in_data_i.radix;
    if (radix_in_w < RADIX_MIN) begin
      radix_in_w = RADIX_MIN;
    end else if (radix_in_w > RADIX_MAX) begin
      radix_in_w = RADIX_MAX;
    end
  end

  // restoring division, BITS_PER_STEP quotient bits per cycle; rem < radix
  always_comb begin
    quot_w  = quot_q;
    rem_w   = rem_q;
    trial_w = '0;
    ge_w    = 1'b0;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      trial_w = {rem_w, quot_w[QUOT_W-1]};
      ge_w    = (trial_w >= radix_q);
      quot_w  = {quot_w[QUOT_W-2:0], ge_w};
      rem_w   = ge_w ? 4'(trial_w - radix_q) : trial_w[3:0];
    end
  end

  // field layout: precision zeros, width pad, prefix, digits
  always_comb begin
    ext_w = 8'(ndig_q) + (ptr_q ? 8'd2 : 8'd0);
    a_w   = ({1'b0, prec_q} > ext_w) ? {1'b0, prec_q} : ext_w;
    if (left_q) begin
      tot_w = a_w;
    end else begin
      tot_w = ({1'b0, width_q} > a_w) ? {1'b0, width_q} : a_w;
    end
  end

  // digits are stored least significant first; emit from the top
  assign raddr_full_w = total_q - 7'd1 - k_q;
  assign raddr_w      = raddr_full_w[DIGIT_AW-1:0];

  always_comb begin
    if (k_q < b_zero_q) begin
      char_w = CH_ZERO;
    end else if (k_q < b_pad_q) begin
      char_w = zpad_q ? CH_ZERO : CH_SPACE;
    end else if (k_q < b_pfx_q) begin
      char_w = (k_q == b_pfx_q - 7'd1) ? CH_X : CH_ZERO;
    end else begin
      char_w = digit_char(rdata_q, upper_q);
    end
  end

  assign sts_o.step_last = (step_q == STEP_W'(DIV_STEPS - 1));
  assign sts_o.div_more  = (quot_w != '0) && ((ndig_q + 7'd1) < CNT_W'(VALUE_BITS));
  assign sts_o.char_last = (k_q == len_q - 7'd1);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      ndig_q      <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        step_q <= '0;
        ndig_q <= '0;
      end else if (cmd_i.div_step) begin
        if (sts_o.step_last) begin
          step_q <= '0;
          ndig_q <= ndig_q + 7'd1;
        end else begin
          step_q <= step_q + 1'b1;
        end
      end
      if (cmd_i.format) begin
        k_q <= '0;
      end else if (cmd_i.emit) begin
        k_q <= k_q + 7'd1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      quot_q  <= QUOT_W'(mag_w);
      rem_q   <= '0;
      radix_q <= radix_in_w;
      upper_q <= in_data_i.uppercase;
      left_q  <= in_data_i.left_justify;
      zpad_q  <= in_data_i.zero_pad;
      ptr_q   <= in_data_i.pointer_prefix && !in_data_i.is_signed;
      width_q <= in_data_i.width;
      prec_q  <= in_data_i.precision;
    end else if (cmd_i.div_step) begin
      quot_q <= quot_w;
      rem_q  <= sts_o.step_last ? 4'd0 : rem_w;
    end
    if (cmd_i.format) begin
      b_zero_q <= 7'(a_w - ext_w);
      b_pad_q  <= 7'(tot_w - ext_w);
      b_pfx_q  <= 7'(tot_w - 8'(ndig_q));
      total_q  <= 7'(tot_w);
      len_q    <= (tot_w > 8'(MAX_CHARS)) ? 7'(MAX_CHARS) : 7'(tot_w);
    end
    if (cmd_i.emit) begin
      out_q.out_char  <= char_w;
      out_q.last_char <= sts_o.char_last;
    end
  end

  // digit store
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_step && sts_o.step_last) begin
      digit_mem[ndig_q[DIGIT_AW-1:0]] <= rem_w;
    end
    rdata_q <= digit_mem[raddr_w];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hdl/integer_to_radix_text_formatter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_radix_text_formatter_unit: printf-style integer formatter
// Converts one value into padded radix text, one ASCII character per
// output transaction.
// ----------------------------------------------------------------------------
//  channel  | signals                          | payload
//  ---------+----------------------------------+---------------------------
//  in       | in_valid_i / in_ready_o          | in_data_i  (itrf_in_t)
//  out      | out_valid_o / out_ready_i        | out_data_o (itrf_out_t)
//
//  Each conversion yields n digits and L output characters (L <= 64);
//  the divider resolves 8 quotient bits per cycle, and each character
//  takes a digit store read plus an output load.
//  One conversion is in flight at a time; in_ready_o rises once the last
//  character is loaded, even while it still waits in the output register.
//  Output stalls hold the sequencer; reset clears all control state.
// ----------------------------------------------------------------------------
module integer_to_radix_text_formatter_unit import itrf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  itrf_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output itrf_out_t out_data_o
);

  itrf_cmd_t cmd;
  itrf_sts_t sts;

  itrf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  itrf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_ready_i (out_ready_i),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for integer_to_radix_text_formatter_unit
// A directed burst covers the corner cases: zero, both integer extremes,
// 64-digit binary text, out-of-range radix, pointer prefix in both modes,
// precision and width padding, left justify and clipped text. Random
// conversions with random idle gaps on both channels follow. Every
// accepted conversion is expanded into its expected character stream,
// and each output transaction is checked against that stream in order.
// ----------------------------------------------------------------------------
module tb_top;
  import itrf_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD      = 400;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  itrf_in_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  itrf_out_t out_data_o;

  itrf_in_t  pending_conversions[$];
  itrf_out_t expected_chars[$];

  int  fail_count   = 0;
  int  conv_count   = 0;
  int  char_count   = 0;
  int  clip_count   = 0;
  int  send_gap     = 0;
  int  recv_stall   = 0;
  int  hold_left    = 0;
  int  holds_asked  = 0;
  int  holds_taken  = 0;
  int  idle_cycles  = 0;
  bit  steady       = 1'b0;

  integer_to_radix_text_formatter_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  // expand one conversion into the characters it must produce
  function automatic void format_text(input itrf_in_t item);
    logic [63:0] mag;
    logic [63:0] base;
    logic [3:0]  digits[64];
    logic [7:0]  text[$];
    logic [7:0]  alpha_base;
    bit          use_prefix;
    int          n, extra, zeros, pads, keep;
    itrf_out_t   ch;

    mag = item.value;
    base = 64'(item.radix);
    if (base < 64'(RADIX_MIN)) base = 64'(RADIX_MIN);
    if (base > 64'(RADIX_MAX)) base = 64'(RADIX_MAX);
    use_prefix = item.pointer_prefix && !item.is_signed;
    alpha_base = item.uppercase ? CH_UP_A : CH_LOW_A;
    // most negative value wraps to itself and still reads as unsigned magnitude
    if (item.is_signed && mag[63]) mag = -mag;

    n = 0;
    do begin
      digits[n] = 4'(mag % base);
      mag = mag / base;
      n++;
    end while (mag != 0 && n < 64);

    extra = use_prefix ? 2 : 0;
    zeros = int'(item.precision) - n - extra;
    if (zeros < 0) zeros = 0;
    pads = item.left_justify ? 0 : int'(item.width) - n - extra - zeros;
    if (pads < 0) pads = 0;

    repeat (zeros) text.push_back(CH_ZERO);
    repeat (pads) text.push_back(item.zero_pad ? CH_ZERO : CH_SPACE);
    if (use_prefix) begin
      text.push_back(CH_ZERO);
      text.push_back(CH_X);
    end
    for (int i = n - 1; i >= 0; i--) begin
      if (digits[i] < 4'd10) text.push_back(CH_ZERO + 8'(digits[i]));
      else text.push_back(alpha_base + 8'(digits[i] - 4'd10));
    end

    keep = (text.size() > MAX_CHARS) ? MAX_CHARS : text.size();
    if (text.size() > MAX_CHARS) clip_count++;
    for (int i = 0; i < keep; i++) begin
      ch.out_char  = text[i];
      ch.last_char = (i == keep - 1);
      expected_chars.push_back(ch);
    end
  endfunction

  function automatic itrf_in_t make_item(input logic [63:0] value, input bit sgn,
                                         input logic [4:0] radix, input bit upper,
                                         input logic [6:0] wid, input logic [6:0] prec,
                                         input bit left, input bit zpad, input bit ptr);
    itrf_in_t item;
    item.value          = value;
    item.is_signed      = sgn;
    item.radix          = radix;
    item.uppercase      = upper;
    item.width          = wid;
    item.precision      = prec;
    item.left_justify   = left;
    item.zero_pad       = zpad;
    item.pointer_prefix = ptr;
    return item;
  endfunction

  function automatic logic [6:0] rand_field_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 7'($urandom_range(0, 12));
    if (r < 95) return 7'($urandom_range(0, 40));
    return 7'($urandom_range(0, 127));
  endfunction

  function automatic itrf_in_t rand_item();
    itrf_in_t    item;
    logic [63:0] v;
    int          r;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2, 3: v = {$urandom, $urandom};
      4, 5:       v = 64'($urandom_range(0, 999));
      6:          v = -64'($urandom_range(1, 999));
      7: begin
        case ($urandom_range(0, 3))
          0: v = 64'd0;
          1: v = {1'b0, {63{1'b1}}};
          2: v = {1'b1, 63'd0};
          default: v = '1;
        endcase
      end
      default:    v = {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
    item.value          = v;
    item.is_signed      = 1'($urandom_range(0, 1));
    item.radix          = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(2, 16))
                                                       : 5'($urandom_range(0, 31));
    item.uppercase      = 1'($urandom_range(0, 1));
    item.width          = rand_field_size();
    item.precision      = rand_field_size();
    item.left_justify   = 1'($urandom_range(0, 1));
    item.zero_pad       = 1'($urandom_range(0, 1));
    item.pointer_prefix = 1'($urandom_range(0, 1));
    return item;
  endfunction

  // sender: offers pending conversions, holds payload until taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      send_gap   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        format_text(in_data_i);
        conv_count++;
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (send_gap > 0) begin
          send_gap   <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_conversions.size() > 0) begin
          in_data_i  <= pending_conversions.pop_front();
          in_valid_i <= 1'b1;
          send_gap   <= steady ? 0 : pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each character transaction, stalls at random
  always @(posedge clk_i or negedge rst_ni) begin
    itrf_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        char_count++;
        if (expected_chars.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] unexpected char 0x%02h last=%0b", $realtime,
                     out_data_o.out_char, out_data_o.last_char);
        end else begin
          want = expected_chars.pop_front();
          if (out_data_o.out_char !== want.out_char ||
              out_data_o.last_char !== want.last_char) begin
            fail_count++;
            if (fail_count <= 10)
              $display("[%0t] char mismatch: exp 0x%02h last=%0b, got 0x%02h last=%0b",
                       $realtime, want.out_char, want.last_char,
                       out_data_o.out_char, out_data_o.last_char);
          end
        end
      end
      if (holds_taken < holds_asked) begin
        holds_taken++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!steady && $urandom_range(0, 99) < 25) recv_stall = pick_gap();
      end
    end
  end

  // watchdog: cycles without any transaction on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no transaction for %0d cycles", $realtime, idle_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic drain_all();
    while (pending_conversions.size() != 0 || in_valid_i || expected_chars.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    // corner cases
    pending_conversions.push_back(make_item(64'd0, 0, 5'd10, 0, 7'd0, 7'd0, 0, 0, 0));
    pending_conversions.push_back(make_item({1'b0, {63{1'b1}}}, 1, 5'd10, 0, 7'd0, 7'd0,
                                            0, 0, 0));
    pending_conversions.push_back(make_item({1'b1, 63'd0}, 1, 5'd10, 0, 7'd0, 7'd0, 0, 0, 0));
    pending_conversions.push_back(make_item({1'b1, 63'd0}, 0, 5'd16, 1, 7'd0, 7'd0, 0, 0, 0));
    pending_conversions.push_back(make_item('1, 0, 5'd2, 0, 7'd0, 7'd0, 0, 0, 0));
    pending_conversions.push_back(make_item('1, 1, 5'd2, 0, 7'd0, 7'd0, 0, 0, 0));
    pending_conversions.push_back(make_item(64'd37, 0, 5'd0, 0, 7'd0, 7'd0, 0, 0, 0));
    pending_conversions.push_back(make_item(64'd37, 0, 5'd1, 0, 7'd0, 7'd0, 0, 0, 0));
    pending_conversions.push_back(make_item(64'hABCD, 0, 5'd17, 1, 7'd0, 7'd0, 0, 0, 0));
    pending_conversions.push_back(make_item(64'hABCD, 0, 5'd31, 0, 7'd0, 7'd0, 0, 0, 0));
    pending_conversions.push_back(make_item(64'hdeadbeefcafef00d, 0, 5'd16, 0, 7'd0, 7'd0,
                                            0, 0, 0));
    pending_conversions.push_back(make_item(64'hdeadbeefcafef00d, 0, 5'd16, 1, 7'd0, 7'd0,
                                            0, 0, 0));
    pending_conversions.push_back(make_item(64'h1f, 0, 5'd16, 0, 7'd20, 7'd0, 0, 1, 1));
    pending_conversions.push_back(make_item(64'h1f, 0, 5'd16, 0, 7'd20, 7'd6, 0, 0, 1));
    pending_conversions.push_back(make_item(-64'sd77, 1, 5'd16, 0, 7'd10, 7'd0, 0, 1, 1));
    pending_conversions.push_back(make_item(-64'sd12345, 1, 5'd10, 0, 7'd40, 7'd30, 0, 0, 0));
    pending_conversions.push_back(make_item(64'd12345, 0, 5'd7, 0, 7'd40, 7'd8, 1, 1, 0));
    pending_conversions.push_back(make_item(64'd5, 0, 5'd3, 1, 7'd1, 7'd1, 0, 1, 0));
    pending_conversions.push_back(make_item(64'd5, 0, 5'd10, 0, 7'd127, 7'd127, 0, 1, 0));
    pending_conversions.push_back(make_item('1, 0, 5'd2, 0, 7'd100, 7'd64, 0, 0, 1));
    pending_conversions.push_back(make_item('1, 0, 5'd2, 0, 7'd127, 7'd0, 0, 1, 1));
    pending_conversions.push_back(make_item(64'd9, 1, 5'd10, 0, 7'd127, 7'd0, 0, 0, 0));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < 130; i++) pending_conversions.push_back(rand_item());
    drain_all();

    // receiver holds off while the sender keeps offering: the formatter must back up
    @(negedge clk_i);
    holds_asked = holds_asked + 1;
    for (int i = 0; i < 10; i++) pending_conversions.push_back(rand_item());
    drain_all();

    // back-to-back stretch with no idling on either side
    @(negedge clk_i);
    steady <= 1'b1;
    for (int i = 0; i < 40; i++) pending_conversions.push_back(rand_item());
    drain_all();
    @(negedge clk_i);
    steady <= 1'b0;
    for (int i = 0; i < 80; i++) pending_conversions.push_back(rand_item());
    drain_all();

    // ready stays high so any stray character shows up
    @(negedge clk_i);
    steady <= 1'b1;
    repeat (60) @(posedge clk_i);

    if (expected_chars.size() != 0) begin
      fail_count++;
      $display("%0d expected characters never arrived", expected_chars.size());
    end
    $display("Ran %0d conversions (%0d clipped to %0d chars), checked %0d characters",
             conv_count, clip_count, MAX_CHARS, char_count);
    $display("Failures: %0d", fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/itrf_pkg.sv
hdl/itrf_ctrl.sv
hdl/itrf_dp.sv
hdl/integer_to_radix_text_formatter_unit.sv
bench/tb_top.sv
